>>> design/keyword_token_match_counter_unit_assert.svh
// Assertion macros for the keyword token match counter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef KEYWORD_TOKEN_MATCH_COUNTER_UNIT_ASSERT_SVH
`define KEYWORD_TOKEN_MATCH_COUNTER_UNIT_ASSERT_SVH

// property that must hold at every edge out of reset
`define KWMC_CHK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("kwmc check failed");

// cause on one edge, effect on the next
`define KWMC_NEXT(lbl, cause, effect) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error("kwmc sequence check failed");

`endif

>>> design/kwmc_pkg.sv
// Shared types, constants and helpers for the keyword token match counter.
// No dependencies.
package kwmc_pkg;

	localparam int MAX_KEYWORDS  = 128;
	localparam int MAX_TOKEN_LEN = 64;

	localparam int KW_IDX_W = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
	localparam int KW_CNT_W = $clog2(MAX_KEYWORDS + 1);
	localparam int POS_W    = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
	localparam int LEN_W    = $clog2(MAX_TOKEN_LEN + 1);
	localparam int WT_W     = 16;
	localparam int MS_W     = 24;

	localparam logic [1:0] FN_KEYWORD = 2'd0;
	localparam logic [1:0] FN_TEXT    = 2'd1;
	localparam logic [1:0] FN_END     = 2'd2;
	localparam logic [1:0] FN_CLEAR   = 2'd3;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_TOTALS = 1'b1;

	typedef logic [MAX_TOKEN_LEN-1:0][7:0] tok_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		tok_t             chars;
	} kw_row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} st_t;

	// top -> matcher
	typedef struct packed {
		logic clr;
		logic vld_s1;
	} scan_ctl_t;

	// matcher -> top
	typedef struct packed {
		logic                busy;
		logic [KW_CNT_W-1:0] hits;
	} scan_sts_t;

	function automatic logic [7:0] sat8(input logic [KW_CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'd255) ? 8'hFF : w[7:0];
	endfunction

endpackage

>>> design/keyword_token_match_counter_unit.sv
// Channel  | handshake            | payload
// item     | item_valid/item_stall | func, data_byte
// result   | result_valid/result_stall | kind, word_matches, total_words,
//          |                      | total_keywords, total_matches, overflow
//
// Keyword bytes, text bytes that are not separators, end and clear are taken
// without a scan. A text separator scans the keyword table one row per cycle
// through the table's read port.
// No items are taken while a scan runs or while a result beat is stalled.
// Reset clears counters only; the table needs no clearing pass.
// Top level of the keyword token match counter.
// Depends on kwmc_pkg, kwmc_kw_mem, kwmc_match and the assertion macro header.
`include "keyword_token_match_counter_unit_assert.svh"

module keyword_token_match_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [7:0]  word_matches,
	output logic [15:0] total_words,
	output logic [7:0]  total_keywords,
	output logic [23:0] total_matches,
	output logic        overflow
);

	kwmc_pkg::st_t                  st_q, st_d;
	logic [kwmc_pkg::KW_CNT_W-1:0]  kw_count_q;
	logic [kwmc_pkg::LEN_W-1:0]     kw_fill_q;
	logic [kwmc_pkg::LEN_W-1:0]     word_len_q;
	logic [kwmc_pkg::WT_W-1:0]      word_total_q;
	logic [kwmc_pkg::MS_W-1:0]      match_sum_q;
	logic                           ovf_q;
	logic [kwmc_pkg::KW_CNT_W-1:0]  issue_cnt_q;
	logic                           rd_vld_s1;
	logic                           out_valid_q;
	kwmc_pkg::tok_t                 word_buf_q;
	kwmc_pkg::tok_t                 kw_stage_q;

	logic                           acc;
	logic                           is_sep;
	logic                           is_comma;
	logic                           kw_we;
	logic                           rd_en;
	logic                           emit_word;
	logic                           load_out;
	logic                           start_scan;
	kwmc_pkg::kw_row_t              wr_row;
	kwmc_pkg::kw_row_t              rd_row_s1;
	kwmc_pkg::scan_ctl_t            ctl;
	kwmc_pkg::scan_sts_t            sts;

	logic                           wt_sat;
	logic [kwmc_pkg::WT_W-1:0]      wt_next;
	logic [kwmc_pkg::MS_W:0]        ms_sum;
	logic [kwmc_pkg::MS_W-1:0]      ms_next;
	logic                           ovf_next;

	assign acc        = item_valid && !item_stall;
	assign is_sep     = (data_byte == kwmc_pkg::CH_SPACE) || (data_byte == kwmc_pkg::CH_NL);
	assign is_comma   = data_byte == kwmc_pkg::CH_COMMA;
	assign start_scan = acc && func == kwmc_pkg::FN_TEXT && is_sep;
	assign kw_we      = acc && func == kwmc_pkg::FN_KEYWORD && is_comma
		&& kw_count_q < kwmc_pkg::KW_CNT_W'(kwmc_pkg::MAX_KEYWORDS);
	assign load_out   = emit_word || (acc && func == kwmc_pkg::FN_END);

	assign wr_row.len   = kw_fill_q;
	assign wr_row.chars = kw_stage_q;

	// --- sequencer ---
	always_comb begin
		st_d       = st_q;
		item_stall = 1'b1;
		rd_en      = 1'b0;
		emit_word  = 1'b0;
		case (st_q)
			kwmc_pkg::ST_IDLE: begin
				item_stall = out_valid_q && result_stall;
				if (item_valid && !item_stall && func == kwmc_pkg::FN_TEXT && is_sep) begin
					st_d = kwmc_pkg::ST_SCAN;
				end
			end
			kwmc_pkg::ST_SCAN: begin
				rd_en = issue_cnt_q < kw_count_q;
				if (!rd_en && !rd_vld_s1 && !sts.busy) begin
					st_d = kwmc_pkg::ST_EMIT;
				end
			end
			kwmc_pkg::ST_EMIT: begin
				if (!out_valid_q || !result_stall) begin
					emit_word = 1'b1;
					st_d      = kwmc_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = kwmc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= kwmc_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// --- saturating totals for a finished word ---
	always_comb begin
		wt_sat   = word_total_q == '1;
		wt_next  = wt_sat ? word_total_q : word_total_q + 1'b1;
		ms_sum   = {1'b0, match_sum_q} + (kwmc_pkg::MS_W + 1)'(sts.hits);
		ms_next  = ms_sum[kwmc_pkg::MS_W] ? '1 : ms_sum[kwmc_pkg::MS_W-1:0];
		ovf_next = ovf_q || wt_sat || ms_sum[kwmc_pkg::MS_W];
	end

	// --- control state ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_count_q   <= '0;
			kw_fill_q    <= '0;
			word_len_q   <= '0;
			word_total_q <= '0;
			match_sum_q  <= '0;
			ovf_q        <= 1'b0;
			issue_cnt_q  <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			out_valid_q <= load_out || (out_valid_q && result_stall);
			if (rd_en) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			if (acc) begin
				case (func)
					kwmc_pkg::FN_KEYWORD: begin
						if (is_comma) begin
							if (kw_we) begin
								kw_count_q <= kw_count_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
							kw_fill_q <= '0;
						end else if (kw_fill_q < kwmc_pkg::LEN_W'(kwmc_pkg::MAX_TOKEN_LEN)) begin
							kw_fill_q <= kw_fill_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					kwmc_pkg::FN_TEXT: begin
						if (is_sep) begin
							issue_cnt_q <= '0;
						end else if (word_len_q < kwmc_pkg::LEN_W'(kwmc_pkg::MAX_TOKEN_LEN)) begin
							word_len_q <= word_len_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					kwmc_pkg::FN_CLEAR: begin
						kw_count_q   <= '0;
						kw_fill_q    <= '0;
						word_len_q   <= '0;
						word_total_q <= '0;
						match_sum_q  <= '0;
						ovf_q        <= 1'b0;
						issue_cnt_q  <= '0;
					end
					default: begin
					end
				endcase
			end
			if (emit_word) begin
				word_total_q <= wt_next;
				match_sum_q  <= ms_next;
				ovf_q        <= ovf_next;
				word_len_q   <= '0;
			end
		end
	end

	// --- token byte buffers ---
	always_ff @(posedge clk) begin
		if (acc && func == kwmc_pkg::FN_KEYWORD && !is_comma
			&& kw_fill_q < kwmc_pkg::LEN_W'(kwmc_pkg::MAX_TOKEN_LEN)) begin
			kw_stage_q[kw_fill_q[kwmc_pkg::POS_W-1:0]] <= data_byte;
		end
		if (acc && func == kwmc_pkg::FN_TEXT && !is_sep
			&& word_len_q < kwmc_pkg::LEN_W'(kwmc_pkg::MAX_TOKEN_LEN)) begin
			word_buf_q[word_len_q[kwmc_pkg::POS_W-1:0]] <= data_byte;
		end
	end

	// --- result register ---
	always_ff @(posedge clk) begin
		if (emit_word) begin
			kind           <= kwmc_pkg::KIND_WORD;
			word_matches   <= kwmc_pkg::sat8(sts.hits);
			total_words    <= wt_next;
			total_keywords <= kwmc_pkg::sat8(kw_count_q);
			total_matches  <= ms_next;
			overflow       <= ovf_next;
		end else if (load_out) begin
			kind           <= kwmc_pkg::KIND_TOTALS;
			word_matches   <= '0;
			total_words    <= word_total_q;
			total_keywords <= kwmc_pkg::sat8(kw_count_q);
			total_matches  <= match_sum_q;
			overflow       <= ovf_q;
		end
	end

	assign result_valid = out_valid_q;

	// table writes happen only in idle and reads only during a scan, so the
	// two never touch the same row in overlapping cycles
	kwmc_kw_mem u_kw_mem (
		.clk      (clk),
		.we       (kw_we),
		.waddr    (kw_count_q[kwmc_pkg::KW_IDX_W-1:0]),
		.wdata    (wr_row),
		.re       (rd_en),
		.raddr    (issue_cnt_q[kwmc_pkg::KW_IDX_W-1:0]),
		.rdata_s1 (rd_row_s1)
	);

	assign ctl.clr    = start_scan;
	assign ctl.vld_s1 = rd_vld_s1;

	kwmc_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.row_s1   (rd_row_s1),
		.word     (word_buf_q),
		.word_len (word_len_q),
		.sts      (sts)
	);

	// --- checks ---
	// the hit count is only meaningful between the start of a scan and its result
	`KWMC_CHK(a_stall_when_busy, (st_q != kwmc_pkg::ST_IDLE) |-> item_stall)
	`KWMC_CHK(a_hits_bound, (st_q != kwmc_pkg::ST_IDLE) |-> (sts.hits <= kw_count_q))
	`KWMC_CHK(a_issue_bound, issue_cnt_q <= kw_count_q)
	`KWMC_NEXT(a_emit_word, emit_word, result_valid && kind == kwmc_pkg::KIND_WORD)

endmodule

>>> design/kwmc_kw_mem.sv
// Keyword table: one row per keyword holding its length and bytes.
// Depends on kwmc_pkg. One write port, one read port with registered data.
module kwmc_kw_mem (
	input  logic                            clk,
	input  logic                            we,
	input  logic [kwmc_pkg::KW_IDX_W-1:0]   waddr,
	input  kwmc_pkg::kw_row_t               wdata,
	input  logic                            re,
	input  logic [kwmc_pkg::KW_IDX_W-1:0]   raddr,
	output kwmc_pkg::kw_row_t               rdata_s1
);

	kwmc_pkg::kw_row_t mem [kwmc_pkg::MAX_KEYWORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

endmodule

>>> design/kwmc_match.sv
// Compare stage: checks one table row against the finished word per cycle
// and counts equal rows. Depends on kwmc_pkg.
module kwmc_match (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kwmc_pkg::scan_ctl_t            ctl,
	input  kwmc_pkg::kw_row_t              row_s1,
	input  kwmc_pkg::tok_t                 word,
	input  logic [kwmc_pkg::LEN_W-1:0]     word_len,
	output kwmc_pkg::scan_sts_t            sts
);

	logic                          eq;
	logic                          diff;
	logic                          hit_s2;
	logic                          vld_s2;
	logic [kwmc_pkg::KW_CNT_W-1:0] hits_q;

	// bytes past the word length are stale in both buffers, so mask them
	always_comb begin
		diff = 1'b0;
		for (int i = 0; i < kwmc_pkg::MAX_TOKEN_LEN; i++) begin
			if (32'(i) < 32'(word_len) && row_s1.chars[i] != word[i]) begin
				diff = 1'b1;
			end
		end
		eq = (row_s1.len == word_len) && !diff;
	end

	always_ff @(posedge clk) begin
		hit_s2 <= eq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			hits_q <= '0;
		end else begin
			vld_s2 <= ctl.vld_s1;
			if (ctl.clr) begin
				hits_q <= '0;
			end else if (vld_s2 && hit_s2) begin
				hits_q <= hits_q + 1'b1;
			end
		end
	end

	assign sts.busy = vld_s2;
	assign sts.hits = hits_q;

endmodule

>>> dv/keyword_token_match_counter_unit_test.sv
// Self-checking testbench for keyword_token_match_counter_unit.
// Drives keyword-list, text, end and clear beats and checks every result beat
// against an in-bench tally model; depends on kwmc_pkg and the RTL only.
module keyword_token_match_counter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WORDS_MAX = 32'h0000_FFFF;
	localparam int unsigned MSUM_MAX  = 32'h00FF_FFFF;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned PHASE_ITEMS = 190;

	typedef struct packed {
		logic        kind;
		logic [7:0]  hits;
		logic [15:0] words;
		logic [7:0]  keywords;
		logic [23:0] msum;
		logic        ovf;
	} tally_t;

	// token of up to 72 bytes, long enough to run past MAX_TOKEN_LEN
	typedef struct packed {
		logic [6:0]       len;
		logic [71:0][7:0] b;
	} token_t;

	class tally_checker;
		logic [7:0]  kw_chars [kwmc_pkg::MAX_KEYWORDS][kwmc_pkg::MAX_TOKEN_LEN];
		int unsigned kw_len [kwmc_pkg::MAX_KEYWORDS];
		int unsigned kw_count, kw_fill;
		logic [7:0]  word_buf [kwmc_pkg::MAX_TOKEN_LEN];
		int unsigned word_len, word_cnt, match_cnt;
		bit          ovf;
		tally_t      expected_tallies[$];
		int unsigned errors, items, word_beats, total_beats;

		function new();
			wipe();
		endfunction

		function void wipe();
			kw_count  = 0;
			kw_fill   = 0;
			word_len  = 0;
			word_cnt  = 0;
			match_cnt = 0;
			ovf       = 1'b0;
		endfunction

		function int unsigned pending();
			return expected_tallies.size();
		endfunction

		function void queue_tally(logic k, int unsigned m);
			tally_t t;
			t.kind     = k;
			t.hits     = (m > 255) ? 8'hFF : 8'(m);
			t.words    = 16'(word_cnt);
			t.keywords = (kw_count > 255) ? 8'hFF : 8'(kw_count);
			t.msum     = 24'(match_cnt);
			t.ovf      = ovf;
			expected_tallies.push_back(t);
		endfunction

		function void note_item(logic [1:0] f, logic [7:0] b);
			int unsigned k, i, m;
			bit same;
			items++;
			case (f)
				kwmc_pkg::FN_KEYWORD: begin
					if (b == kwmc_pkg::CH_COMMA) begin
						if (kw_count < kwmc_pkg::MAX_KEYWORDS) begin
							kw_len[kw_count] = kw_fill;
							kw_count++;
						end else begin
							ovf = 1'b1;
						end
						kw_fill = 0;
					end else if (kw_fill >= kwmc_pkg::MAX_TOKEN_LEN) begin
						ovf = 1'b1;
					end else begin
						// bytes of a keyword that will be dropped are not kept
						if (kw_count < kwmc_pkg::MAX_KEYWORDS)
							kw_chars[kw_count][kw_fill] = b;
						kw_fill++;
					end
				end
				kwmc_pkg::FN_TEXT: begin
					if (b != kwmc_pkg::CH_SPACE && b != kwmc_pkg::CH_NL) begin
						if (word_len >= kwmc_pkg::MAX_TOKEN_LEN) begin
							ovf = 1'b1;
						end else begin
							word_buf[word_len] = b;
							word_len++;
						end
					end else begin
						m = 0;
						for (k = 0; k < kw_count; k++) begin
							if (kw_len[k] == word_len) begin
								same = 1'b1;
								for (i = 0; i < word_len; i++)
									if (kw_chars[k][i] != word_buf[i])
										same = 1'b0;
								if (same)
									m++;
							end
						end
						if (word_cnt >= WORDS_MAX)
							ovf = 1'b1;
						else
							word_cnt++;
						if (m > MSUM_MAX - match_cnt) begin
							match_cnt = MSUM_MAX;
							ovf = 1'b1;
						end else begin
							match_cnt += m;
						end
						word_len = 0;
						queue_tally(kwmc_pkg::KIND_WORD, m);
					end
				end
				kwmc_pkg::FN_END: begin
					queue_tally(kwmc_pkg::KIND_TOTALS, 0);
				end
				default: begin
					wipe();
				end
			endcase
		endfunction

		function int unsigned report(string name, logic [23:0] e, logic [23:0] a);
			if (e === a)
				return 0;
			if (errors < 50)
				$display("%t %s mismatch: expected %0d actual %0d", $realtime, name, e, a);
			return 1;
		endfunction

		function void check_tally(tally_t got);
			tally_t want;
			int unsigned bad;
			if (expected_tallies.size() == 0) begin
				if (errors < 50)
					$display("%t result beat with nothing expected: kind %0d matches %0d",
						$realtime, got.kind, got.hits);
				errors++;
				return;
			end
			want = expected_tallies.pop_front();
			if (want.kind == kwmc_pkg::KIND_WORD)
				word_beats++;
			else
				total_beats++;
			bad = report("kind", 24'(want.kind), 24'(got.kind));
			bad += report("word_matches", 24'(want.hits), 24'(got.hits));
			bad += report("total_words", 24'(want.words), 24'(got.words));
			bad += report("total_keywords", 24'(want.keywords), 24'(got.keywords));
			bad += report("total_matches", want.msum, got.msum);
			bad += report("overflow", 24'(want.ovf), 24'(got.ovf));
			errors += bad;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  func = kwmc_pkg::FN_KEYWORD;
	logic [7:0]  data_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        kind;
	logic [7:0]  word_matches;
	logic [15:0] total_words;
	logic [7:0]  total_keywords;
	logic [23:0] total_matches;
	logic        overflow;

	tally_checker sb = new();
	int unsigned  src_idle_pct = 27;
	int unsigned  dst_idle_pct = 65;
	int unsigned  hold_req = 0;
	int unsigned  hold_left = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  sent_items = 0;

	keyword_token_match_counter_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.func           (func),
		.data_byte      (data_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.word_matches   (word_matches),
		.total_words    (total_words),
		.total_keywords (total_keywords),
		.total_matches  (total_matches),
		.overflow       (overflow)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// result side: random stall, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (dst_idle_pct != 0) && ($urandom_range(99) < dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_tally({kind, word_matches, total_words, total_keywords,
					total_matches, overflow});
			if (item_valid && !item_stall)
				sb.note_item(func, data_byte);
			if ((result_valid && !result_stall) || (item_valid && !item_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%t no beat moved for %0d cycles, %0d results outstanding",
					$realtime, QUIET_LIMIT, sb.pending());
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] f, input logic [7:0] d);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		func       <= f;
		data_byte  <= d;
		do
			@(posedge clk);
		while (item_stall);
		sent_items++;
	endtask

	// drop valid, wait for every expected beat, then an optional tail
	task automatic drain(input int unsigned tail);
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	function automatic logic [7:0] content_byte(logic [1:0] f);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while ((f == kwmc_pkg::FN_KEYWORD && b == kwmc_pkg::CH_COMMA) ||
			(f == kwmc_pkg::FN_TEXT && (b == kwmc_pkg::CH_SPACE || b == kwmc_pkg::CH_NL)));
		return b;
	endfunction

	// mostly short tokens over a tiny alphabet so that words hit keywords
	function automatic token_t make_token(logic [1:0] f);
		token_t t;
		int unsigned r, i;
		t = '0;
		r = $urandom_range(99);
		if (r < 10)
			t.len = 0;
		else if (r < 85)
			t.len = 7'($urandom_range(1, 3));
		else if (r < 95)
			t.len = 7'($urandom_range(1, 6));
		else
			t.len = 7'($urandom_range(kwmc_pkg::MAX_TOKEN_LEN - 4,
				kwmc_pkg::MAX_TOKEN_LEN + 6));
		for (i = 0; i < t.len; i++)
			t.b[i] = (r >= 85 && r < 95) ? content_byte(f) : 8'(8'h61 + $urandom_range(2));
		return t;
	endfunction

	task automatic send_token(input logic [1:0] f, input token_t t);
		int unsigned i;
		for (i = 0; i < t.len; i++)
			send_item(f, t.b[i]);
	endtask

	// keyword list, then text drawn mostly from it, then end of text
	task automatic run_sequence();
		token_t vocab[$];
		token_t t;
		int unsigned n_kw, n_words, i;
		if ($urandom_range(4) == 0)
			send_item(kwmc_pkg::FN_CLEAR, 8'($urandom_range(255)));
		n_kw = $urandom_range(6);
		for (i = 0; i < n_kw; i++) begin
			t = make_token(kwmc_pkg::FN_KEYWORD);
			vocab.push_back(t);
			send_token(kwmc_pkg::FN_KEYWORD, t);
			send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		end
		n_words = $urandom_range(1, 8);
		for (i = 0; i < n_words; i++) begin
			if (vocab.size() != 0 && $urandom_range(9) < 6)
				t = vocab[$urandom_range(vocab.size() - 1)];
			else
				t = make_token(kwmc_pkg::FN_TEXT);
			send_token(kwmc_pkg::FN_TEXT, t);
			send_item(kwmc_pkg::FN_TEXT,
				$urandom_range(1) ? kwmc_pkg::CH_SPACE : kwmc_pkg::CH_NL);
			// keyword slipped in mid-text: later words see the grown table
			if ($urandom_range(9) == 0) begin
				t = make_token(kwmc_pkg::FN_KEYWORD);
				vocab.push_back(t);
				send_token(kwmc_pkg::FN_KEYWORD, t);
				send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
			end
		end
		if ($urandom_range(9) < 2)
			send_token(kwmc_pkg::FN_TEXT, make_token(kwmc_pkg::FN_TEXT));
		if ($urandom_range(9) < 8)
			send_item(kwmc_pkg::FN_END, 8'($urandom_range(255)));
	endtask

	task automatic run_random(input int unsigned n_items);
		int unsigned stop_at, n;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			if ($urandom_range(9) < 8) begin
				run_sequence();
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_item(($urandom_range(99) < 3) ? kwmc_pkg::FN_CLEAR
					: 2'($urandom_range(2)), 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty word on an empty table, then blanks, zero and all-ones bytes
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		send_item(kwmc_pkg::FN_END, 8'hFF);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_KEYWORD, 8'h00);
		send_item(kwmc_pkg::FN_KEYWORD, 8'hFF);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_KEYWORD, 8'h00);
		send_item(kwmc_pkg::FN_KEYWORD, 8'hFF);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_NL);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_SPACE);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_NL);
		send_item(kwmc_pkg::FN_TEXT, 8'h00);
		send_item(kwmc_pkg::FN_TEXT, 8'hFF);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		// word left open across end of text, matched by a keyword added later
		send_item(kwmc_pkg::FN_TEXT, 8'h41);
		send_item(kwmc_pkg::FN_END, 8'h00);
		send_item(kwmc_pkg::FN_KEYWORD, 8'h41);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_NL);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		send_item(kwmc_pkg::FN_CLEAR, 8'h5A);
		send_item(kwmc_pkg::FN_END, 8'h00);

		// token length at and past the limit
		repeat (kwmc_pkg::MAX_TOKEN_LEN) send_item(kwmc_pkg::FN_KEYWORD, 8'h79);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		repeat (kwmc_pkg::MAX_TOKEN_LEN) send_item(kwmc_pkg::FN_TEXT, 8'h79);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		repeat (kwmc_pkg::MAX_TOKEN_LEN + 3) send_item(kwmc_pkg::FN_TEXT, 8'h79);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_NL);
		repeat (kwmc_pkg::MAX_TOKEN_LEN + 6) send_item(kwmc_pkg::FN_KEYWORD, 8'h7A);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		repeat (kwmc_pkg::MAX_TOKEN_LEN) send_item(kwmc_pkg::FN_TEXT, 8'h7A);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		send_item(kwmc_pkg::FN_END, 8'h00);

		// full table of empty keywords, then one that is dropped
		send_item(kwmc_pkg::FN_CLEAR, 8'h00);
		repeat (kwmc_pkg::MAX_KEYWORDS) send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		send_item(kwmc_pkg::FN_END, 8'h00);
		send_item(kwmc_pkg::FN_KEYWORD, 8'h61);
		send_item(kwmc_pkg::FN_KEYWORD, kwmc_pkg::CH_COMMA);
		send_item(kwmc_pkg::FN_TEXT, 8'h61);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_NL);
		send_item(kwmc_pkg::FN_END, 8'h00);
		drain(0);

		// result side held off while separators keep arriving
		send_item(kwmc_pkg::FN_CLEAR, 8'h00);
		hold_req = 300;
		repeat (12) send_item(kwmc_pkg::FN_TEXT, kwmc_pkg::CH_SPACE);
		drain(0);

		run_random(PHASE_ITEMS);
		drain(0);
		src_idle_pct = 65;
		dst_idle_pct = 27;
		run_random(PHASE_ITEMS);
		drain(0);
		src_idle_pct = 0;
		dst_idle_pct = 0;
		run_random(PHASE_ITEMS);

		drain(200);
		$display("%0d input beats checked into %0d word results and %0d totals results",
			sb.items, sb.word_beats, sb.total_beats);
		$display("covered long tokens, a full keyword table, mid-text keywords and stalls");
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/kwmc_pkg.sv
design/kwmc_kw_mem.sv
design/kwmc_match.sv
design/keyword_token_match_counter_unit.sv
dv/keyword_token_match_counter_unit_test.sv
